// File: design/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants for the circular byte FIFO
// Holds the item structs, command codes, sequencer states and the request and
// response structs of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package cbf_pkg;

    // Fixed field widths
    localparam int CNT_W   = 13;             // counts, lengths, depth register
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 3;
    localparam int BURST_W = 5;
    localparam int ALU_W   = CNT_W + 1;      // one spare bit carries the borrow
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    // Package defaults for the top-level parameters
    localparam int DEPTH_DEF     = 4096;
    localparam int MAX_BURST_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REWIND = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  data_byte;
        logic [BURST_W-1:0] burst_len;
        logic [CNT_W-1:0]   rewind_len;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic [CNT_W-1:0]  granted;
        logic [CNT_W-1:0]  fill_level;
    } t_out_item;

    // Shared adder request / response
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] y;
        logic             lt;    // a < b when sub is set
    } t_alu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WR_CHK,
        S_WR_MEM,
        S_WR_WRAP,
        S_WR_FILL,
        S_RD_LIM,
        S_RD_FILL,
        S_RD_ADDR,
        S_RD_WRAP,
        S_RW_FREE,
        S_RW_CHK,
        S_RW_SUB,
        S_RW_DIFF,
        S_RW_WRAP,
        S_RW_FILL,
        S_OUT
    } t_state;

endpackage

// File: design/circular_byte_fifo_peek_rewind_unit.sv
// ----------------------------------------------------------------------------
// circular_byte_fifo_peek_rewind_unit: circular byte FIFO with peek and rewind
// Byte ring with read/write pointers and a fill count, driven by a small
// sequencer around one shared add/subtract unit.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------
//  config    | in        | i_cfg_we                | i_cfg_data (depth)
//  command   | in        | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  result    | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
//  Every pointer step, wrap check, fill update and limit check is a sequencer
//  state of its own, served by the single shared adder. Reset clears pointers
//  and fill and loads the full depth; the byte store holds no reset state. A
//  stalled result holds the sequencer in place; a new command is taken only
//  once the last result of the previous one is gone.
//
module circular_byte_fifo_peek_rewind_unit
    import cbf_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    // command channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    localparam int AW        = $clog2(DEPTH);
    localparam int DEPTH_RST = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state               r_state;
    t_state               n_state;

    logic [BYTE_W-1:0]    r_mem [DEPTH];
    logic [BYTE_W-1:0]    r_rdata;

    logic [CNT_W-1:0]     r_depth;     // ring depth in use, already clamped
    logic [CNT_W-1:0]     r_fill;
    logic [AW-1:0]        r_rpos;
    logic [AW-1:0]        r_wpos;

    t_in_item             r_item;      // command being worked on
    logic [AW-1:0]        r_pos;       // walking read position for a burst
    logic [BURST_W-1:0]   r_n;         // bytes granted to a burst
    logic [BURST_W-1:0]   r_idx;       // byte index within a burst
    logic [ALU_W-1:0]     r_tmp;       // scratch for the shared adder
    t_out_item            r_out;

    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;

    logic                 in_xfer;
    logic                 out_xfer;
    logic [BURST_W-1:0]   burst_clamp;
    logic                 is_burst;
    logic                 burst_done;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = o_out_valid && !i_out_stall;
    assign is_burst   = (r_item.cmd == CMD_READ) || (r_item.cmd == CMD_PEEK);
    assign burst_done = !is_burst || r_out.last;

    // saturate the requested burst to the largest burst supported
    assign burst_clamp = (int'(r_item.burst_len) > MAX_BURST) ? BURST_W'(MAX_BURST)
                                                               : r_item.burst_len;

    cbf_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.cmd)
                        CMD_WRITE:  n_state = S_WR_CHK;
                        CMD_READ:   n_state = S_RD_LIM;
                        CMD_PEEK:   n_state = S_RD_LIM;
                        CMD_REWIND: n_state = S_RW_FREE;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_WR_CHK:  n_state = alu_rsp.lt ? S_WR_MEM : S_OUT;
            S_WR_MEM:  n_state = S_WR_WRAP;
            S_WR_WRAP: n_state = S_WR_FILL;
            S_WR_FILL: n_state = S_OUT;
            S_RD_LIM:  n_state = S_RD_FILL;
            S_RD_FILL: n_state = (r_n == '0) ? S_OUT : S_RD_ADDR;
            S_RD_ADDR: n_state = S_RD_WRAP;
            S_RD_WRAP: n_state = S_OUT;
            S_RW_FREE: n_state = S_RW_CHK;
            S_RW_CHK:  n_state = alu_rsp.lt ? S_OUT : S_RW_SUB;
            S_RW_SUB:  n_state = alu_rsp.lt ? S_RW_DIFF : S_RW_FILL;
            S_RW_DIFF: n_state = S_RW_WRAP;
            S_RW_WRAP: n_state = S_RW_FILL;
            S_RW_FILL: n_state = S_OUT;
            S_OUT: begin
                if (out_xfer) begin
                    n_state = burst_done ? S_IDLE : S_RD_ADDR;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs and operand selection for the shared adder
    // ------------------------------------------------------------------
    always_comb begin
        alu_req     = '0;
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT);
        o_out_data  = r_out;
        case (r_state)
            // fill < depth: room for one more byte
            S_WR_CHK: begin
                alu_req = '{a: ALU_W'(r_fill), b: ALU_W'(r_depth), sub: 1'b1};
            end
            // advance the write pointer
            S_WR_MEM: begin
                alu_req = '{a: ALU_W'(r_wpos), b: ALU_W'(1), sub: 1'b0};
            end
            S_WR_WRAP, S_RD_WRAP: begin
                alu_req = '{a: r_tmp, b: ALU_W'(r_depth), sub: 1'b1};
            end
            S_WR_FILL: begin
                alu_req = '{a: ALU_W'(r_fill), b: ALU_W'(1), sub: 1'b0};
            end
            // fill < burst: limit the burst to what is stored
            S_RD_LIM: begin
                alu_req = '{a: ALU_W'(r_fill), b: ALU_W'(burst_clamp), sub: 1'b1};
            end
            S_RD_FILL: begin
                alu_req = '{a: ALU_W'(r_fill), b: ALU_W'(r_n), sub: 1'b1};
            end
            S_RD_ADDR: begin
                alu_req = '{a: ALU_W'(r_pos), b: ALU_W'(1), sub: 1'b0};
            end
            // free space = depth - fill
            S_RW_FREE: begin
                alu_req = '{a: ALU_W'(r_depth), b: ALU_W'(r_fill), sub: 1'b1};
            end
            S_RW_CHK: begin
                alu_req = '{a: r_tmp, b: ALU_W'(r_item.rewind_len), sub: 1'b1};
            end
            S_RW_SUB: begin
                alu_req = '{a: ALU_W'(r_rpos), b: ALU_W'(r_item.rewind_len), sub: 1'b1};
            end
            S_RW_DIFF: begin
                alu_req = '{a: ALU_W'(r_item.rewind_len), b: ALU_W'(r_rpos), sub: 1'b1};
            end
            // wrapped rewind lands at depth - (len - pos), never on depth itself
            S_RW_WRAP: begin
                alu_req = '{a: ALU_W'(r_depth), b: r_tmp, sub: 1'b1};
            end
            S_RW_FILL: begin
                alu_req = '{a: ALU_W'(r_fill), b: ALU_W'(r_item.rewind_len), sub: 1'b0};
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // byte store: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR_MEM) begin
            r_mem[r_wpos] <= r_item.data_byte;
        end
        if (r_state == S_RD_ADDR) begin
            r_rdata <= r_mem[r_pos];
        end
    end

    // ------------------------------------------------------------------
    // sequencer and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= CNT_W'(DEPTH_RST);
            r_fill  <= '0;
            r_rpos  <= '0;
            r_wpos  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_WR_WRAP: begin
                    // drop back to slot 0 when the pointer reaches the depth
                    r_wpos <= alu_rsp.lt ? AW'(r_tmp) : '0;
                end
                S_WR_FILL: begin
                    r_fill <= CNT_W'(alu_rsp.y);
                end
                S_RD_FILL: begin
                    if (r_n != '0 && r_item.cmd == CMD_READ) begin
                        r_fill <= CNT_W'(alu_rsp.y);
                    end
                end
                S_RW_SUB: begin
                    if (!alu_rsp.lt) begin
                        r_rpos <= AW'(alu_rsp.y);
                    end
                end
                S_RW_WRAP: begin
                    r_rpos <= AW'(alu_rsp.y);
                end
                S_RW_FILL: begin
                    r_fill <= CNT_W'(alu_rsp.y);
                end
                S_OUT: begin
                    // commit the read pointer once the burst is fully handed off
                    if (out_xfer && r_out.last && r_item.cmd == CMD_READ) begin
                        r_rpos <= r_pos;
                    end
                end
                S_IDLE: begin
                    if (in_xfer && i_in_data.cmd == CMD_FLUSH) begin
                        r_fill <= '0;
                        r_rpos <= r_wpos;
                    end
                end
                default: begin
                end
            endcase
            // configuration must arrive only while idle (the block does not enforce it); it restarts the ring
            if (i_cfg_we) begin
                if (i_cfg_data == '0) begin
                    r_depth <= CNT_W'(1);
                end else if (int'(i_cfg_data) > DEPTH) begin
                    r_depth <= CNT_W'(DEPTH_RST);
                end else begin
                    r_depth <= i_cfg_data;
                end
                r_fill <= '0;
                r_rpos <= '0;
                r_wpos <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload and scratch registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_item <= i_in_data;
                    // flush and unknown commands go straight to the result state
                    r_out  <= '{out_byte: '0, byte_valid: 1'b0, last: 1'b1,
                                granted: '0,
                                fill_level: (i_in_data.cmd == CMD_FLUSH) ? '0 : r_fill};
                end
            end
            S_WR_CHK: begin
                r_out <= '{out_byte: '0, byte_valid: 1'b0, last: 1'b1,
                           granted: '0, fill_level: r_fill};
            end
            S_WR_MEM, S_RD_ADDR, S_RW_FREE, S_RW_DIFF: begin
                r_tmp <= alu_rsp.y;
            end
            S_WR_FILL: begin
                r_out <= '{out_byte: '0, byte_valid: 1'b0, last: 1'b1,
                           granted: CNT_W'(1), fill_level: CNT_W'(alu_rsp.y)};
            end
            S_RD_LIM: begin
                r_n   <= alu_rsp.lt ? BURST_W'(r_fill) : burst_clamp;
                r_pos <= r_rpos;
                r_idx <= '0;
            end
            S_RD_FILL: begin
                // nothing to give: a single empty result
                r_out <= '{out_byte: '0, byte_valid: 1'b0, last: 1'b1,
                           granted: '0, fill_level: r_fill};
            end
            S_RD_WRAP: begin
                r_pos <= alu_rsp.lt ? AW'(r_tmp) : '0;
                r_out <= '{out_byte: r_rdata, byte_valid: 1'b1,
                           last: ((r_idx + BURST_W'(1)) == r_n),
                           granted: CNT_W'(r_n), fill_level: r_fill};
            end
            S_RW_CHK: begin
                r_out <= '{out_byte: '0, byte_valid: 1'b0, last: 1'b1,
                           granted: '0, fill_level: r_fill};
            end
            S_RW_FILL: begin
                r_out <= '{out_byte: '0, byte_valid: 1'b0, last: 1'b1,
                           granted: r_item.rewind_len, fill_level: CNT_W'(alu_rsp.y)};
            end
            S_OUT: begin
                if (out_xfer && !burst_done) begin
                    r_idx <= r_idx + BURST_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    // the fill count never passes the ring depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_depth)
        else $error("fill count above ring depth");

    // both pointers stay inside the ring
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_rpos) < r_depth) && (CNT_W'(r_wpos) < r_depth))
        else $error("pointer outside ring");

    // a result on offer blocks new commands
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("command taken while a result is pending");

    // a configuration write leaves the ring empty
    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_fill == '0) && (r_rpos == '0) && (r_wpos == '0))
        else $error("ring not empty after configuration write");

    // a result without a byte always closes its command
    a_nodata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.byte_valid) |-> o_out_data.last)
        else $error("non-data result not marked last");
`endif

endmodule

// File: design/cbf_alu.sv
// ----------------------------------------------------------------------------
// cbf_alu: shared add/subtract unit
// One adder that serves every pointer, fill and limit computation; the
// borrow of a subtraction doubles as the less-than compare.
// ----------------------------------------------------------------------------
module cbf_alu
    import cbf_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W-1:0] b_eff;

    assign b_eff   = i_req.sub ? ~i_req.b : i_req.b;
    assign o_rsp.y = i_req.a + b_eff + ALU_W'(i_req.sub);
    // operands are zero-extended by one bit, so the top bit is the borrow
    assign o_rsp.lt = i_req.sub & o_rsp.y[ALU_W-1];

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for circular_byte_fifo_peek_rewind_unit
// Runs a short scripted pass over every command and corner (empty, full,
// saturated burst, refused rewind, pointer wrap, depth register limits), then
// random command streams at several ring depths. Results are checked against
// scripted values or a cycle-free ring model; both channels idle at random.
// ----------------------------------------------------------------------------
module testbench
    import cbf_pkg::*;
();

    localparam int RING_SLOTS      = DEPTH_DEF;
    localparam int BURST_CAP       = MAX_BURST_DEF;
    localparam int HOLD_AT_RESULT  = 70;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 12;
    localparam int IDLE_SETTLE     = 4;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TAIL_CYCLES     = 80;
    localparam int RUN_LIMIT       = 10_000_000;

    // codes above flush are unused by the block
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_FLUSH + 3'd1;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;
    localparam logic [CNT_W-1:0] LEN_ALL_ONES    = '1;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_in_item         item;
        logic [CNT_W-1:0] depth;
        logic [CNT_W-1:0] want_granted;
        logic [CNT_W-1:0] want_fill;
    } t_script_row;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;

    // ring model
    logic [CNT_W-1:0]  depth_reg = CNT_W'(RING_SLOTS);
    int unsigned       rd_pos;
    int unsigned       wr_pos;
    int unsigned       fill;
    logic [BYTE_W-1:0] ring [RING_SLOTS];
    bit                written [RING_SLOTS];

    t_out_item   step_out [$];
    t_out_item   due_results [$];
    t_script_row script [$];
    int          phase_depths [$] = '{9, 8191, 2, 20, 4096, 1, 37};

    int mismatch_count = 0;
    int results_taken  = 0;
    int phase_items    = 0;
    int tx_calm        = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    circular_byte_fifo_peek_rewind_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic int unsigned ring_size();
        if (depth_reg == 0) begin
            return 1;
        end
        if (depth_reg > RING_SLOTS) begin
            return RING_SLOTS;
        end
        return depth_reg;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_in_item noisy_item(input logic [CMD_W-1:0] cmd);
        logic [31:0] bits;
        t_in_item    it;
        bits    = $urandom;
        it      = bits[$bits(t_in_item)-1:0];
        it.cmd  = cmd;
        return it;
    endfunction

    // Apply one command to the ring model; leave its results in step_out.
    task automatic predict_fifo_results(input t_in_item it);
        int unsigned d;
        int unsigned n;
        int unsigned pos;
        int unsigned rlen;
        t_out_item   r;
        d    = ring_size();
        rlen = it.rewind_len;
        r    = '0;
        r.last = 1'b1;
        step_out.delete();
        case (it.cmd)
            CMD_WRITE: begin
                if (fill < d) begin
                    ring[wr_pos]    = it.data_byte;
                    written[wr_pos] = 1'b1;
                    wr_pos          = (wr_pos + 1 >= d) ? 0 : wr_pos + 1;
                    fill++;
                    r.granted = 1;
                end
            end
            CMD_READ, CMD_PEEK: begin
                n = it.burst_len;
                if (n > BURST_CAP) n = BURST_CAP;
                if (n > fill) n = fill;
                if (n != 0) begin
                    pos = rd_pos;
                    if (it.cmd == CMD_READ) fill -= n;
                    for (int i = 0; i < n; i++) begin
                        r.out_byte   = ring[pos];
                        r.byte_valid = 1'b1;
                        r.last       = (i + 1 == n);
                        r.granted    = CNT_W'(n);
                        r.fill_level = CNT_W'(fill);
                        step_out.push_back(r);
                        pos = (pos + 1 >= d) ? 0 : pos + 1;
                    end
                    if (it.cmd == CMD_READ) rd_pos = pos;
                end
            end
            CMD_REWIND: begin
                if (rlen <= d - fill) begin
                    rd_pos    = (rd_pos >= rlen) ? rd_pos - rlen : d - (rlen - rd_pos);
                    fill     += rlen;
                    r.granted = CNT_W'(rlen);
                end
            end
            CMD_FLUSH: begin
                fill   = 0;
                rd_pos = wr_pos;
            end
            default: begin
            end
        endcase
        if (step_out.size() == 0) begin
            r.fill_level = CNT_W'(fill);
            step_out.push_back(r);
        end
    endtask

    // Offer one command, book its results on acceptance, then maybe idle.
    task automatic push_cmd(input t_in_item it, input bit typed,
                            input logic [CNT_W-1:0] g, input logic [CNT_W-1:0] f);
        t_out_item w;
        int        n;
        i_in_data  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_fifo_results(it);
        if (typed) begin
            w            = '0;
            w.last       = 1'b1;
            w.granted    = g;
            w.fill_level = f;
            due_results.push_back(w);
        end else begin
            foreach (step_out[k]) due_results.push_back(step_out[k]);
        end
        @(negedge i_clk);
        if (tx_calm > 0) begin
            tx_calm--;
            n = 0;
        end else if ($urandom_range(0, 99) < 4) begin
            tx_calm = $urandom_range(10, 40);
            n = 0;
        end else begin
            n = gap_len();
        end
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Write the depth register once the block has gone quiet.
    task automatic apply_depth(input logic [CNT_W-1:0] v);
        i_in_valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (IDLE_SETTLE) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        depth_reg = v;
        rd_pos    = 0;
        wr_pos    = 0;
        fill      = 0;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [CMD_W-1:0] cmd,
                           input logic [BYTE_W-1:0] data, input logic [BURST_W-1:0] burst,
                           input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] g,
                           input logic [CNT_W-1:0] f);
        t_script_row row;
        row                 = '0;
        row.kind            = kind;
        row.item.cmd        = cmd;
        row.item.data_byte  = data;
        row.item.burst_len  = burst;
        row.item.rewind_len = len;
        row.depth           = len;    // config rows carry the depth in len
        row.want_granted    = g;
        row.want_fill       = f;
        script.push_back(row);
    endtask

    // result side: random stall, one long hold-off, field-by-field check
    initial begin
        int  stall_left;
        int  calm_left;
        bit  held;
        t_out_item want;
        string     tag;
        stall_left = 0;
        calm_left  = 0;
        held       = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                tag = $sformatf("result %0d", results_taken);
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("%s with nothing due: %h", tag, o_out_data));
                end else begin
                    want = due_results.pop_front();
                    if (o_out_data.out_byte !== want.out_byte)
                        flag_mismatch($sformatf("%s out_byte %h, want %h", tag,
                                                o_out_data.out_byte, want.out_byte));
                    if (o_out_data.byte_valid !== want.byte_valid)
                        flag_mismatch($sformatf("%s byte_valid %b, want %b", tag,
                                                o_out_data.byte_valid, want.byte_valid));
                    if (o_out_data.last !== want.last)
                        flag_mismatch($sformatf("%s last %b, want %b", tag,
                                                o_out_data.last, want.last));
                    if (o_out_data.granted !== want.granted)
                        flag_mismatch($sformatf("%s granted %0d, want %0d", tag,
                                                o_out_data.granted, want.granted));
                    if (o_out_data.fill_level !== want.fill_level)
                        flag_mismatch($sformatf("%s fill_level %0d, want %0d", tag,
                                                o_out_data.fill_level, want.fill_level));
                end
                results_taken++;
            end
            @(negedge i_clk);
            if (!held && results_taken >= HOLD_AT_RESULT) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 99) < 4) begin
                    calm_left = $urandom_range(20, 60);
                end else begin
                    stall_left = gap_len();
                end
            end
            i_out_stall = (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    initial begin
        t_script_row row;
        t_in_item    it;
        int          r;
        int          n;
        int          free_slots;
        int          safe;
        int          slot;
        int          waited;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // scripted pass: empty ring, unused codes, limits, wrap at depth 1
        add_row(ROW_TYPED,   CMD_READ,        8'h00, 5'd3,  '0,           0, 0);
        add_row(ROW_TYPED,   CMD_PEEK,        8'h00, 5'd0,  '0,           0, 0);
        add_row(ROW_TYPED,   CMD_REWIND,      8'h00, 5'd0,  LEN_ALL_ONES, 0, 0);
        add_row(ROW_TYPED,   CMD_FLUSH,       8'h00, 5'd0,  '0,           0, 0);
        add_row(ROW_TYPED,   CMD_SPARE_FIRST, 8'h00, 5'd0,  '0,           0, 0);
        add_row(ROW_TYPED,   CMD_SPARE_LAST - 3'd1, 8'h00, 5'd0, '0,      0, 0);
        add_row(ROW_TYPED,   CMD_SPARE_LAST,  8'h00, 5'd0,  '0,           0, 0);
        add_row(ROW_TYPED,   CMD_WRITE,       8'h00, 5'd0,  '0,           1, 1);
        add_row(ROW_TYPED,   CMD_WRITE,       8'hFF, 5'd0,  '0,           1, 2);
        add_row(ROW_TYPED,   CMD_WRITE,       8'hA5, 5'd0,  '0,           1, 3);
        add_row(ROW_TYPED,   CMD_WRITE,       8'h5A, 5'd0,  '0,           1, 4);
        add_row(ROW_TYPED,   CMD_PEEK,        8'h00, 5'd0,  '0,           0, 4);
        add_row(ROW_PREDICT, CMD_PEEK,        8'h00, 5'd31, '0,           0, 0);
        add_row(ROW_PREDICT, CMD_READ,        8'h00, 5'd2,  '0,           0, 0);
        add_row(ROW_TYPED,   CMD_REWIND,      8'h00, 5'd0,  13'd2,        2, 4);
        add_row(ROW_PREDICT, CMD_READ,        8'h00, 5'd16, '0,           0, 0);
        add_row(ROW_TYPED,   CMD_REWIND,      8'h00, 5'd0,  13'd0,        0, 0);
        add_row(ROW_TYPED,   CMD_REWIND,      8'h00, 5'd0,  CNT_W'(RING_SLOTS + 1), 0, 0);
        add_row(ROW_CFG,     CMD_WRITE,       8'h00, 5'd0,  13'd0,        0, 0);
        add_row(ROW_TYPED,   CMD_WRITE,       8'h3C, 5'd0,  '0,           1, 1);
        add_row(ROW_TYPED,   CMD_WRITE,       8'hC3, 5'd0,  '0,           0, 1);
        add_row(ROW_PREDICT, CMD_READ,        8'h00, 5'd31, '0,           0, 0);
        add_row(ROW_TYPED,   CMD_REWIND,      8'h00, 5'd0,  13'd1,        1, 1);
        add_row(ROW_PREDICT, CMD_PEEK,        8'h00, 5'd1,  '0,           0, 0);
        add_row(ROW_TYPED,   CMD_FLUSH,       8'h00, 5'd0,  '0,           0, 0);

        foreach (script[k]) begin
            row = script[k];
            if (row.kind == ROW_CFG) begin
                apply_depth(row.depth);
            end else begin
                push_cmd(row.item, row.kind == ROW_TYPED, row.want_granted, row.want_fill);
            end
        end

        // random streams, one phase per ring depth
        foreach (phase_depths[p]) begin
            apply_depth(CNT_W'(phase_depths[p]));
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        push_cmd(noisy_item(CMD_WRITE), 1'b0, '0, '0);
                        phase_items++;
                    end
                end else if (r < 72) begin
                    it = noisy_item((r < 58) ? CMD_READ : CMD_PEEK);
                    n  = $urandom_range(0, 9);
                    if (n == 0) it.burst_len = '0;
                    else if (n == 1)
                        it.burst_len = BURST_W'($urandom_range(BURST_CAP + 1, 31));
                    else it.burst_len = BURST_W'($urandom_range(1, BURST_CAP));
                    push_cmd(it, 1'b0, '0, '0);
                    phase_items++;
                end else if (r < 88) begin
                    // never expose a slot that was never written
                    free_slots = ring_size() - fill;
                    slot       = rd_pos;
                    safe       = 0;
                    while (safe < free_slots) begin
                        slot = (slot == 0) ? ring_size() - 1 : slot - 1;
                        if (!written[slot]) break;
                        safe++;
                    end
                    it = noisy_item(CMD_REWIND);
                    n  = $urandom_range(0, 99);
                    if (n < 50) it.rewind_len = CNT_W'($urandom_range(0, safe));
                    else if (n < 65) it.rewind_len = CNT_W'(safe);
                    else if (n < 85) it.rewind_len = CNT_W'($urandom_range(free_slots + 1,
                                                                           free_slots + 8));
                    else it.rewind_len = CNT_W'($urandom_range(free_slots + 1, LEN_ALL_ONES));
                    push_cmd(it, 1'b0, '0, '0);
                    phase_items++;
                end else if (r < 94) begin
                    push_cmd(noisy_item(CMD_FLUSH), 1'b0, '0, '0);
                    phase_items++;
                end else begin
                    push_cmd(noisy_item(CMD_W'($urandom_range(CMD_SPARE_FIRST,
                                                              CMD_SPARE_LAST))),
                             1'b0, '0, '0);
                    phase_items++;
                end
            end
        end

        i_in_valid = 1'b0;
        waited     = 0;
        while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (due_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", due_results.size()));
        if (mismatch_count == 0) begin
            $display("[circular_byte_fifo_peek_rewind_unit] OK");
        end else begin
            $display("[circular_byte_fifo_peek_rewind_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("[circular_byte_fifo_peek_rewind_unit] ERROR");
        $finish;
    end

endmodule

// File: files.f
design/cbf_pkg.sv
design/cbf_alu.sv
design/circular_byte_fifo_peek_rewind_unit.sv
verif/testbench.sv
